// ===== hdl/serial_ring_buffered_line_io_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the serial ring buffer datapath
// ---------------------------------------------------------------------------
`ifndef SERIAL_RING_BUFFERED_LINE_IO_MACROS_SVH
`define SERIAL_RING_BUFFERED_LINE_IO_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SRB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/srb_pkg.sv =====
// ---------------------------------------------------------------------------
// srb_pkg
// Types and constants shared by the serial ring buffer controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package srb_pkg;

  // request codes on in_req_type
  localparam logic [2:0] REQ_RX     = 3'd0;
  localparam logic [2:0] REQ_TX_RDY = 3'd1;
  localparam logic [2:0] REQ_RD     = 3'd2;
  localparam logic [2:0] REQ_WR     = 3'd3;
  localparam logic [2:0] REQ_OPEN   = 3'd4;
  localparam logic [2:0] REQ_CLOSE  = 3'd5;

  // error codes on out_error_code
  localparam logic [2:0] ERR_OK     = 3'd0;
  localparam logic [2:0] ERR_CLOSED = 3'd1;
  localparam logic [2:0] ERR_BUSY   = 3'd2;
  localparam logic [2:0] ERR_OPEN   = 3'd3;
  localparam logic [2:0] ERR_COUNT  = 3'd4;

  localparam logic [7:0] TERM_RESET = 8'd13;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_WRITE = 2'd2
  } chan_status_t;

  // datapath commands issued by the controller
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_SINGLE,
    CMD_RD_START,
    CMD_FETCH,
    CMD_TAKE,
    CMD_TERM,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic read_go;    // latched request is a read start that passes all checks
    logic can_load;   // output register free this cycle
    logic more;       // count not met and store not empty
    logic rd_term;    // fetched store byte is the terminator
    logic held;       // a delivered byte is held back for lookahead
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/srb_ctrl.sv =====
// ---------------------------------------------------------------------------
// srb_ctrl
// Sequencer: takes one request at a time and steps the datapath through a
// single-result request or the drain of the receive store for a read start.
// ---------------------------------------------------------------------------
`default_nettype none

module srb_ctrl
  import srb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t sts,
  output cmd_t            cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_CHECK,
    S_END
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_CAPTURE;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (sts.read_go) begin
          cmd       = CMD_RD_START;
          state_nxt = S_FETCH;
        end else if (sts.can_load) begin
          cmd       = CMD_SINGLE;
          state_nxt = S_IDLE;
        end else begin
          // result register still occupied
          state_nxt = state_r;
        end
      end
      S_FETCH: begin
        if (sts.more) begin
          cmd       = CMD_FETCH;
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_END;
        end
      end
      S_CHECK: begin
        // the held byte goes out only once the next one is known not to end the read
        priority if (sts.rd_term) begin
          cmd       = CMD_TERM;
          state_nxt = S_END;
        end else if (!sts.held || sts.can_load) begin
          cmd       = CMD_TAKE;
          state_nxt = S_FETCH;
        end else begin
          state_nxt = state_r;
        end
      end
      S_END: begin
        if (sts.can_load) begin
          cmd       = CMD_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/srb_dpath.sv =====
// ---------------------------------------------------------------------------
// srb_dpath
// Channel state, receive ring store, request latch and result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "serial_ring_buffered_line_io_macros.svh"

module srb_dpath
  import srb_pkg::*;
#(
  parameter int RING_DEPTH  = 128,
  parameter int MAX_REQUEST = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cmd_t       cmd,
  output dp_status_t      sts,
  input  wire logic [2:0] in_req_type,
  input  wire logic [7:0] in_data_byte,
  input  wire logic [6:0] in_request_count,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_error_code,
  output logic            out_deliver_valid,
  output logic [7:0]      out_deliver_byte,
  output logic [5:0]      out_deliver_index,
  output logic            out_tx_valid,
  output logic [7:0]      out_tx_byte,
  output logic [6:0]      out_tx_next_index,
  output logic            out_done_flag,
  output logic [6:0]      out_done_count,
  output logic            out_last
);

  localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W = $clog2(RING_DEPTH + 1);

  typedef struct packed {
    logic [2:0] err;
    logic       dv;
    logic [7:0] db;
    logic [5:0] di;
    logic       tv;
    logic [7:0] tb;
    logic [6:0] tn;
    logic       df;
    logic [6:0] dc;
    logic       last;
  } result_t;

  logic [7:0]       mem [RING_DEPTH];
  logic [7:0]       rdata_r;
  logic             rd_en, mem_we;

  logic [7:0]       term_r;
  logic [2:0]       req_r,  req_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [6:0]       cnt_r,  cnt_nxt;

  logic             open_r, open_nxt;
  chan_status_t     status_r, status_nxt;
  logic [PTR_W-1:0] in_ptr_r, in_ptr_nxt;
  logic [PTR_W-1:0] out_ptr_r, out_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [6:0]       done_r, done_nxt;
  logic [6:0]       total_r, total_nxt;
  logic             held_v_r, held_v_nxt;
  logic [7:0]       held_byte_r, held_byte_nxt;
  logic [5:0]       held_idx_r, held_idx_nxt;
  logic             term_hit_r, term_hit_nxt;

  result_t          res, res_r;
  logic             load;
  logic             out_valid_r;
  logic             can_load;
  logic [6:0]       done_inc;
  logic             fin;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign can_load = !out_valid_r || !out_stall;
  assign done_inc = done_r + 7'd1;

  assign sts.read_go  = (req_r == REQ_RD) && open_r && (status_r == ST_IDLE)
                        && (cnt_r <= 7'(MAX_REQUEST));
  assign sts.can_load = can_load;
  assign sts.more     = (done_r < total_r) && (fill_r != '0);
  assign sts.rd_term  = (rdata_r == term_r);
  assign sts.held     = held_v_r;

  always_comb begin
    res           = '0;
    res.last      = 1'b1;
    load          = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    fin           = 1'b0;
    req_nxt       = req_r;
    byte_nxt      = byte_r;
    cnt_nxt       = cnt_r;
    open_nxt      = open_r;
    status_nxt    = status_r;
    in_ptr_nxt    = in_ptr_r;
    out_ptr_nxt   = out_ptr_r;
    fill_nxt      = fill_r;
    done_nxt      = done_r;
    total_nxt     = total_r;
    held_v_nxt    = held_v_r;
    held_byte_nxt = held_byte_r;
    held_idx_nxt  = held_idx_r;
    term_hit_nxt  = term_hit_r;

    unique case (cmd)
      CMD_NONE: begin
      end
      CMD_CAPTURE: begin
        req_nxt  = in_req_type;
        byte_nxt = in_data_byte;
        cnt_nxt  = in_request_count;
      end
      CMD_SINGLE: begin
        load = 1'b1;
        unique case (req_r)
          REQ_RX: begin
            if (open_r) begin
              if (status_r == ST_READ) begin
                if (byte_r == term_r) begin
                  status_nxt = ST_IDLE;
                  res.df     = 1'b1;
                  res.dc     = done_r;
                end else begin
                  fin      = (done_inc >= total_r);
                  done_nxt = done_inc;
                  if (fin) begin
                    status_nxt = ST_IDLE;
                  end
                  res.dv = 1'b1;
                  res.db = byte_r;
                  res.di = done_r[5:0];
                  res.df = fin;
                  res.dc = fin ? done_inc : 7'd0;
                end
              end else if (fill_r < FILL_W'(RING_DEPTH)) begin
                // room left: store it; a byte meeting a full store is dropped
                mem_we     = 1'b1;
                in_ptr_nxt = ptr_inc(in_ptr_r);
                fill_nxt   = fill_r + FILL_W'(1);
              end
            end
          end
          REQ_TX_RDY: begin
            if (open_r && status_r == ST_WRITE) begin
              if (done_r < total_r) begin
                done_nxt = done_inc;
                res.tv   = 1'b1;
                res.tb   = byte_r;
                res.tn   = done_inc;
              end else begin
                status_nxt = ST_IDLE;
                res.df     = 1'b1;
                res.dc     = done_r;
              end
            end
          end
          REQ_RD, REQ_WR: begin
            // a read start that passes its checks never reaches here
            priority if (!open_r) begin
              res.err = ERR_CLOSED;
            end else if (status_r != ST_IDLE) begin
              res.err = ERR_BUSY;
            end else if (cnt_r > 7'(MAX_REQUEST)) begin
              res.err = ERR_COUNT;
            end else begin
              total_nxt = cnt_r;
              if (cnt_r == 7'd0) begin
                done_nxt = 7'd0;
                res.df   = 1'b1;
              end else begin
                done_nxt   = 7'd1;
                status_nxt = ST_WRITE;
                res.tv     = 1'b1;
                res.tb     = byte_r;
                res.tn     = 7'd1;
              end
            end
          end
          REQ_OPEN: begin
            if (open_r) begin
              res.err = ERR_OPEN;
            end else begin
              open_nxt    = 1'b1;
              status_nxt  = ST_IDLE;
              in_ptr_nxt  = '0;
              out_ptr_nxt = '0;
              fill_nxt    = '0;
              done_nxt    = 7'd0;
              total_nxt   = 7'd0;
            end
          end
          REQ_CLOSE: begin
            if (!open_r) begin
              res.err = ERR_CLOSED;
            end else begin
              open_nxt = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      CMD_RD_START: begin
        total_nxt    = cnt_r;
        done_nxt     = 7'd0;
        status_nxt   = ST_READ;
        held_v_nxt   = 1'b0;
        term_hit_nxt = 1'b0;
      end
      CMD_FETCH: begin
        rd_en = 1'b1;
      end
      CMD_TAKE: begin
        // previous held byte is not the last one: send it now
        load          = held_v_r;
        res.dv        = 1'b1;
        res.db        = held_byte_r;
        res.di        = held_idx_r;
        res.last      = 1'b0;
        out_ptr_nxt   = ptr_inc(out_ptr_r);
        fill_nxt      = fill_r - FILL_W'(1);
        held_v_nxt    = 1'b1;
        held_byte_nxt = rdata_r;
        held_idx_nxt  = done_r[5:0];
        done_nxt      = done_inc;
      end
      CMD_TERM: begin
        out_ptr_nxt  = ptr_inc(out_ptr_r);
        fill_nxt     = fill_r - FILL_W'(1);
        term_hit_nxt = 1'b1;
      end
      CMD_FINISH: begin
        fin        = term_hit_r || (done_r >= total_r);
        status_nxt = fin ? ST_IDLE : ST_READ;
        load       = 1'b1;
        res.dv     = held_v_r;
        res.db     = held_v_r ? held_byte_r : 8'd0;
        res.di     = held_v_r ? held_idx_r : 6'd0;
        res.df     = fin;
        res.dc     = fin ? done_r : 7'd0;
        held_v_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // receive store, registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_ptr_r] <= byte_r;
    end
    if (rd_en) begin
      rdata_r <= mem[out_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r     <= TERM_RESET;
      open_r     <= 1'b0;
      status_r   <= ST_IDLE;
      in_ptr_r   <= '0;
      out_ptr_r  <= '0;
      fill_r     <= '0;
      done_r     <= 7'd0;
      total_r    <= 7'd0;
      held_v_r   <= 1'b0;
      term_hit_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        term_r <= cfg_wr_data;
      end
      open_r     <= open_nxt;
      status_r   <= status_nxt;
      in_ptr_r   <= in_ptr_nxt;
      out_ptr_r  <= out_ptr_nxt;
      fill_r     <= fill_nxt;
      done_r     <= done_nxt;
      total_r    <= total_nxt;
      held_v_r   <= held_v_nxt;
      term_hit_r <= term_hit_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    byte_r      <= byte_nxt;
    cnt_r       <= cnt_nxt;
    held_byte_r <= held_byte_nxt;
    held_idx_r  <= held_idx_nxt;
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_error_code    = res_r.err;
  assign out_deliver_valid = res_r.dv;
  assign out_deliver_byte  = res_r.db;
  assign out_deliver_index = res_r.di;
  assign out_tx_valid      = res_r.tv;
  assign out_tx_byte       = res_r.tb;
  assign out_tx_next_index = res_r.tn;
  assign out_done_flag     = res_r.df;
  assign out_done_count    = res_r.dc;
  assign out_last          = res_r.last;

  `SRB_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FILL_W'(RING_DEPTH), "store fill above depth")
  `SRB_ASSERT_IMPL(a_done_bound, clk, rst_n, 1'b1, done_r <= total_r, "transfer count past total")
  `SRB_ASSERT_IMPL(a_no_overwrite, clk, rst_n, load, !(out_valid_r && out_stall), "stalled result overwritten")
  `SRB_ASSERT_IMPL(a_fetch_ok, clk, rst_n, cmd == CMD_FETCH, (status_r == ST_READ) && (fill_r != '0), "store read while not draining or empty")
  `SRB_ASSERT_NEXT(a_finish_release, clk, rst_n, cmd == CMD_FINISH, !held_v_r && out_valid_r, "drain end left a held byte")

endmodule

`default_nettype wire

// ===== hdl/serial_ring_buffered_line_io.sv =====
// ---------------------------------------------------------------------------
// serial_ring_buffered_line_io
// Buffered serial channel: receive ring store, read drain and byte-wise write.
// ---------------------------------------------------------------------------
// Requests enter on in_* (valid/stall) one at a time; results leave on out_*
// through a single output register, out_last marking the final one of each
// request. The terminator byte is written on cfg_wr_en/cfg_wr_data; the user
// must write it only while idle, the block itself does not enforce this. A
// request other than a passing read start gives exactly one result: it is
// taken, evaluated once the result register is free, and the result is
// registered before the next request is taken. A passing read start drains
// the receive store byte by byte (registered store read, then a one-byte
// lookahead says if the held byte is the last), with set-up and wind-down.
// in_stall is high whenever a request is being worked on.
// When the receiver stalls, the result register holds and the sequencer waits
// before loading the next result; a new request may be taken while a result
// still waits. Reset closes the port, clears the channel state and pointers
// and sets the terminator to carriage return; store contents are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module serial_ring_buffered_line_io
  import srb_pkg::*;
#(
  parameter int RING_DEPTH  = 128,
  parameter int MAX_REQUEST = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_req_type,
  input  wire logic [7:0] in_data_byte,
  input  wire logic [6:0] in_request_count,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_error_code,
  output logic            out_deliver_valid,
  output logic [7:0]      out_deliver_byte,
  output logic [5:0]      out_deliver_index,
  output logic            out_tx_valid,
  output logic [7:0]      out_tx_byte,
  output logic [6:0]      out_tx_next_index,
  output logic            out_done_flag,
  output logic [6:0]      out_done_count,
  output logic            out_last,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  cmd_t       cmd;
  dp_status_t sts;

  srb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  srb_dpath #(
    .RING_DEPTH  (RING_DEPTH),
    .MAX_REQUEST (MAX_REQUEST)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_data_byte      (in_data_byte),
    .in_request_count  (in_request_count),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_error_code    (out_error_code),
    .out_deliver_valid (out_deliver_valid),
    .out_deliver_byte  (out_deliver_byte),
    .out_deliver_index (out_deliver_index),
    .out_tx_valid      (out_tx_valid),
    .out_tx_byte       (out_tx_byte),
    .out_tx_next_index (out_tx_next_index),
    .out_done_flag     (out_done_flag),
    .out_done_count    (out_done_count),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire
